// ----- design/nd_index_ravel_unravel_top_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ND_INDEX_RAVEL_UNRAVEL_TOP_MACROS_SVH
`define ND_INDEX_RAVEL_UNRAVEL_TOP_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define NIRX_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("nirx assertion failed");

// next-cycle implication
`define NIRX_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("nirx assertion failed");

`endif

// ----- design/nirx_pkg.sv -----
// Shared constants, types and helpers of the index converter.
package nirx_pkg;

	localparam int LANES     = 4;
	localparam int LIN_W     = 48;
	localparam int CRD_W     = 12;
	localparam int EXT_W     = 13;
	localparam int MOD_W     = LIN_W + 1;
	localparam int MOD_STEPS = LIN_W;
	localparam int DIV_STEPS = CRD_W;
	localparam int LAT       = MOD_STEPS + DIV_STEPS;
	localparam int SETTLE    = LANES + 1;
	localparam int PROD_W    = LIN_W + EXT_W;

	typedef enum logic [2:0] {
		REG_NUM_AXES = 3'd0,
		REG_EXTENT_0 = 3'd1,
		REG_EXTENT_1 = 3'd2,
		REG_EXTENT_2 = 3'd3,
		REG_EXTENT_3 = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic             in_use;
		logic [EXT_W-1:0] extent;
		logic [LIN_W-1:0] stride;
		logic [MOD_W-1:0] modulus;
	} lane_cfg_t;

	// zero reads as one, anything past 4096 saturates
	function automatic logic [EXT_W-1:0] eff_extent(input logic [EXT_W-1:0] e);
		logic [EXT_W-1:0] r;
		r = e;
		if (e == '0) r = EXT_W'(1);
		if (e > EXT_W'(4096)) r = EXT_W'(4096);
		return r;
	endfunction

	function automatic logic [2:0] axes_in_use(input logic [2:0] na);
		logic [2:0] r;
		r = na;
		if (na == 3'd0) r = 3'd1;
		if (na > 3'(LANES)) r = 3'(LANES);
		return r;
	endfunction

endpackage

// ----- design/nirx_stride.sv -----
// Stride and modulus registers, relaxed from the extent registers.
module nirx_stride (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic [2:0]                           num_axes,
	input  logic [nirx_pkg::LANES-1:0][nirx_pkg::EXT_W-1:0] extent,
	output nirx_pkg::lane_cfg_t [nirx_pkg::LANES-1:0]       cfg
);
	logic [nirx_pkg::LANES-1:0][nirx_pkg::LIN_W-1:0] stride_q;
	logic [nirx_pkg::LANES-1:0][nirx_pkg::MOD_W-1:0] mod_q;
	logic [nirx_pkg::LANES-1:0][nirx_pkg::EXT_W-1:0] eff;
	logic [2:0] n;

	always_comb begin
		n = nirx_pkg::axes_in_use(num_axes);
		for (int a = 0; a < nirx_pkg::LANES; a++) begin
			eff[a] = nirx_pkg::eff_extent(extent[a]);
			cfg[a].in_use  = (3'(a) < n);
			cfg[a].extent  = eff[a];
			cfg[a].stride  = stride_q[a];
			cfg[a].modulus = mod_q[a];
		end
	end

	// strides ripple from the last axis in use toward axis 0; moduli follow
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < nirx_pkg::LANES; a++) begin
				stride_q[a] <= (a == 0) ? nirx_pkg::LIN_W'(1) : '0;
				mod_q[a]    <= (a == 0) ? nirx_pkg::MOD_W'(1) : '0;
			end
		end else begin
			for (int a = 0; a < nirx_pkg::LANES; a++) begin
				if (3'(a) >= n)
					stride_q[a] <= '0;
				else if (3'(a) == n - 3'd1)
					stride_q[a] <= nirx_pkg::LIN_W'(1);
				else if (a < nirx_pkg::LANES - 1)
					stride_q[a] <= nirx_pkg::LIN_W'(nirx_pkg::PROD_W'(stride_q[a+1])
						* nirx_pkg::PROD_W'(eff[a+1]));
				else
					stride_q[a] <= '0;
				mod_q[a] <= nirx_pkg::MOD_W'(nirx_pkg::PROD_W'(stride_q[a])
					* nirx_pkg::PROD_W'(eff[a]));
			end
		end
	end
endmodule

// ----- design/nirx_lane.sv -----
// One axis lane: coordinate times stride, and a bit-serial mod / divide pipeline.
module nirx_lane (
	input  logic                          clk,
	input  logic                          adv,
	input  logic [nirx_pkg::LIN_W-1:0]    lin_s0,
	input  logic [nirx_pkg::CRD_W-1:0]    crd_s0,
	input  nirx_pkg::lane_cfg_t           cfg,
	output logic [nirx_pkg::LIN_W-1:0]    prod_s1,
	output logic                          bad_s1,
	output logic [nirx_pkg::CRD_W-1:0]    crd_out
);
	localparam int MS = nirx_pkg::MOD_STEPS;
	localparam int LT = nirx_pkg::LAT;
	localparam int SW = nirx_pkg::MOD_W + nirx_pkg::CRD_W;

	logic [nirx_pkg::MOD_W-1:0] rem_s [1:MS];
	logic [nirx_pkg::LIN_W-1:0] lsh_s [1:MS];
	logic [nirx_pkg::MOD_W-1:0] dr_s  [MS+1:LT];
	logic [nirx_pkg::CRD_W-1:0] dq_s  [MS+1:LT];
	logic [nirx_pkg::MOD_W-1:0] rem_n [1:MS];
	logic [nirx_pkg::LIN_W-1:0] lsh_n [1:MS];
	logic [nirx_pkg::MOD_W-1:0] dr_n  [MS+1:LT];
	logic [nirx_pkg::CRD_W-1:0] dq_n  [MS+1:LT];

	// remainder by stride*extent, one dividend bit a stage
	always_comb begin
		logic [nirx_pkg::MOD_W-1:0] pr;
		logic [nirx_pkg::LIN_W-1:0] pl;
		logic [nirx_pkg::MOD_W-1:0] t;
		for (int k = 1; k <= MS; k++) begin
			pr = (k == 1) ? '0 : rem_s[k-1];
			pl = (k == 1) ? lin_s0 : lsh_s[k-1];
			t  = {pr[nirx_pkg::MOD_W-2:0], pl[nirx_pkg::LIN_W-1]};
			rem_n[k] = (t >= cfg.modulus) ? t - cfg.modulus : t;
			lsh_n[k] = {pl[nirx_pkg::LIN_W-2:0], 1'b0};
		end
	end

	// quotient of that remainder by the stride: below the extent, so CRD_W bits
	always_comb begin
		logic [nirx_pkg::MOD_W-1:0] pr;
		logic [nirx_pkg::CRD_W-1:0] pq;
		logic [SW-1:0] sh;
		for (int k = MS + 1; k <= LT; k++) begin
			pr = (k == MS + 1) ? rem_s[MS] : dr_s[k-1];
			pq = (k == MS + 1) ? '0 : dq_s[k-1];
			sh = SW'(cfg.stride) << (LT - k);
			if (SW'(pr) >= sh) begin
				dr_n[k] = nirx_pkg::MOD_W'(SW'(pr) - sh);
				dq_n[k] = {pq[nirx_pkg::CRD_W-2:0], 1'b1};
			end else begin
				dr_n[k] = pr;
				dq_n[k] = {pq[nirx_pkg::CRD_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s1 <= cfg.in_use ? nirx_pkg::LIN_W'(nirx_pkg::PROD_W'(crd_s0)
				* nirx_pkg::PROD_W'(cfg.stride)) : '0;
			bad_s1  <= cfg.in_use && (nirx_pkg::EXT_W'(crd_s0) >= cfg.extent);
			for (int k = 1; k <= MS; k++) begin
				rem_s[k] <= rem_n[k];
				lsh_s[k] <= lsh_n[k];
			end
			for (int k = MS + 1; k <= LT; k++) begin
				dr_s[k] <= dr_n[k];
				dq_s[k] <= dq_n[k];
			end
		end
	end

	assign crd_out = cfg.in_use ? dq_s[LT] : '0;
endmodule

// ----- design/nd_index_ravel_unravel_top.sv -----
// Top level of the row-major index converter (ravel / unravel).
//
//  channel   dir   handshake                  payload
//  s_axis    in    tvalid / tready            tdata (coords, offset), tuser (req_type)
//  m_axis    out   tvalid / tready            tdata (offset, coords), tuser (status)
//  apb       in    psel/penable/pwrite/pready paddr, pwdata, prdata
//
// One item a cycle sustained while m_axis takes results and no register write is settling;
// every item passes the 48 remainder stages and 12 quotient stages of the axis lanes.
// The whole pipeline moves together and halts while a result waits on m_axis.
// After reset and after any register write, s_axis_tready stays low while the stride
// registers settle.
// Reset clears the registers to one axis of extent one and empties the pipeline.
module nd_index_ravel_unravel_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [95:0] s_axis_tdata,   // linear_index[47:0], coord_0..coord_3 12b each
	input  logic [0:0]  s_axis_tuser,   // req_type
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [95:0] m_axis_tdata,   // linear_out[47:0], coord_out_0..coord_out_3 12b each
	output logic [0:0]  m_axis_tuser,   // status
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	localparam int L  = nirx_pkg::LANES;
	localparam int LT = nirx_pkg::LAT;
	localparam int LW = nirx_pkg::LIN_W;
	localparam int CW = nirx_pkg::CRD_W;

	// registers
	logic [2:0] num_axes_q;
	logic [L-1:0][nirx_pkg::EXT_W-1:0] extent_q;
	logic [2:0] settle_q;
	nirx_pkg::reg_idx_t widx;
	logic wr;

	nirx_pkg::lane_cfg_t [L-1:0] cfg;

	// pipeline control and payload
	logic vld_s [0:LT];
	logic typ_s [0:LT];
	logic [LW-1:0] lin_s0;
	logic [L-1:0][CW-1:0] crd_s0;
	logic [L-1:0][LW-1:0] prod_s1;
	logic [L-1:0] bad_s1;
	logic [L-1:0][CW-1:0] crd_out;
	logic [LW-1:0] sum01_s2, sum23_s2;
	logic bad_s2;
	logic [LW-1:0] rav_s [3:LT];
	logic rbad_s [3:LT];
	logic adv, take;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;
	assign widx   = nirx_pkg::reg_idx_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_axes_q <= 3'd1;
			for (int a = 0; a < L; a++) extent_q[a] <= nirx_pkg::EXT_W'(1);
			settle_q   <= 3'(nirx_pkg::SETTLE);
		end else begin
			if (wr) begin
				settle_q <= 3'(nirx_pkg::SETTLE);
				case (widx)
					nirx_pkg::REG_NUM_AXES: num_axes_q  <= pwdata[2:0];
					nirx_pkg::REG_EXTENT_0: extent_q[0] <= pwdata[12:0];
					nirx_pkg::REG_EXTENT_1: extent_q[1] <= pwdata[12:0];
					nirx_pkg::REG_EXTENT_2: extent_q[2] <= pwdata[12:0];
					nirx_pkg::REG_EXTENT_3: extent_q[3] <= pwdata[12:0];
					default: ;
				endcase
			end else if (settle_q != 3'd0) begin
				settle_q <= settle_q - 3'd1;
			end
		end
	end

	always_comb begin
		case (widx)
			nirx_pkg::REG_NUM_AXES: prdata = {29'd0, num_axes_q};
			nirx_pkg::REG_EXTENT_0: prdata = {19'd0, extent_q[0]};
			nirx_pkg::REG_EXTENT_1: prdata = {19'd0, extent_q[1]};
			nirx_pkg::REG_EXTENT_2: prdata = {19'd0, extent_q[2]};
			nirx_pkg::REG_EXTENT_3: prdata = {19'd0, extent_q[3]};
			default:                prdata = '0;
		endcase
	end

	nirx_stride u_stride (
		.clk      (clk),
		.arst_n   (arst_n),
		.num_axes (num_axes_q),
		.extent   (extent_q),
		.cfg      (cfg)
	);

	// whole pipeline steps unless the output register holds an untaken item
	assign adv           = !vld_s[LT] || m_axis_tready;
	assign s_axis_tready = adv && (settle_q == 3'd0);
	assign take          = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= LT; k++) vld_s[k] <= 1'b0;
		end else if (adv) begin
			vld_s[0] <= take;
			for (int k = 1; k <= LT; k++) vld_s[k] <= vld_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			typ_s[0] <= s_axis_tuser[0];
			lin_s0   <= s_axis_tdata[LW-1:0];
			for (int a = 0; a < L; a++) crd_s0[a] <= s_axis_tdata[LW + a*CW +: CW];
			for (int k = 1; k <= LT; k++) typ_s[k] <= typ_s[k-1];
		end
	end

	for (genvar a = 0; a < L; a++) begin : g_lane
		nirx_lane u_lane (
			.clk     (clk),
			.adv     (adv),
			.lin_s0  (lin_s0),
			.crd_s0  (crd_s0[a]),
			.cfg     (cfg[a]),
			.prod_s1 (prod_s1[a]),
			.bad_s1  (bad_s1[a]),
			.crd_out (crd_out[a])
		);
	end

	// ravel merge: pair sums, then final sum, then delay to line up with unravel
	always_ff @(posedge clk) begin
		if (adv) begin
			sum01_s2 <= prod_s1[0] + prod_s1[1];
			sum23_s2 <= prod_s1[2] + prod_s1[3];
			bad_s2   <= |bad_s1;
			rav_s[3]  <= bad_s2 ? '0 : sum01_s2 + sum23_s2;
			rbad_s[3] <= bad_s2;
			for (int k = 4; k <= LT; k++) begin
				rav_s[k]  <= rav_s[k-1];
				rbad_s[k] <= rbad_s[k-1];
			end
		end
	end

	assign m_axis_tvalid = vld_s[LT];
	always_comb begin
		m_axis_tdata[LW-1:0] = typ_s[LT] ? '0 : rav_s[LT];
		for (int a = 0; a < L; a++)
			m_axis_tdata[LW + a*CW +: CW] = typ_s[LT] ? crd_out[a] : '0;
		m_axis_tuser[0] = !typ_s[LT] && rbad_s[LT];
	end
endmodule

// ----- design/nirx_checker.sv -----
// Port-level checker for the index converter, bound to the top level.
`include "nd_index_ravel_unravel_top_macros.svh"

module nirx_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [95:0] s_axis_tdata,
	input logic [0:0]  s_axis_tuser,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [95:0] m_axis_tdata,
	input logic [0:0]  m_axis_tuser,
	input logic        psel,
	input logic        penable,
	input logic        pwrite,
	input logic [4:0]  paddr,
	input logic [31:0] pwdata,
	input logic [31:0] prdata,
	input logic        pready
);
	// a stalled result item holds
	`NIRX_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
	// an out-of-range ravel carries an all-zero payload
	`NIRX_ASSERT_NOW(a_err_zero, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata == 96'd0)
	// no item taken while strides settle after a write
	`NIRX_ASSERT_NEXT(a_cfg_block, psel && penable && pwrite && pready, !s_axis_tready)
endmodule

bind nd_index_ravel_unravel_top nirx_checker u_nirx_checker (.*);

// ----- tb/tb.sv -----
// Self-checking bench for the row-major index converter: ravel and unravel traffic, APB setup.
`timescale 1ns / 100ps

// Expected results of the converter, kept in acceptance order
class conv_scoreboard;
	typedef struct {
		logic [47:0] lin;
		logic [11:0] crd [4];
		logic        status;
	} conv_result_t;

	logic [2:0]  na;
	logic [12:0] ext [4];
	logic [47:0] stride [4];
	conv_result_t pending [$];
	int errors;

	function new();
		na = 3'd1;
		for (int a = 0; a < 4; a++) ext[a] = 13'd1;
		errors = 0;
		refresh();
	endfunction

	function int axes();
		int n;
		n = na;
		if (n == 0) n = 1;
		if (n > 4) n = 4;
		return n;
	endfunction

	function longint unsigned eff_ext(int a);
		longint unsigned e;
		e = ext[a];
		if (e == 0) e = 1;
		if (e > 4096) e = 4096;
		return e;
	endfunction

	function void refresh();
		longint unsigned s;
		s = 1;
		for (int a = 0; a < 4; a++) stride[a] = '0;
		for (int a = axes() - 1; a >= 0; a--) begin
			stride[a] = s[47:0];
			s = (s * eff_ext(a)) & 64'hFFFF_FFFF_FFFF;
		end
	endfunction

	function void write_reg(int idx, logic [31:0] v);
		if (idx == nirx_pkg::REG_NUM_AXES) na = v[2:0];
		else if (idx >= nirx_pkg::REG_EXTENT_0 && idx <= nirx_pkg::REG_EXTENT_3)
			ext[idx - nirx_pkg::REG_EXTENT_0] = v[12:0];
		else return;
		refresh();
	endfunction

	// span of the whole array, 2^48 at most
	function longint unsigned span();
		return longint'(stride[0]) * eff_ext(0);
	endfunction

	function void note_item(logic unravel, logic [47:0] lin, logic [11:0] c [4]);
		conv_result_t r;
		longint unsigned acc;
		r.lin = '0;
		r.status = 1'b0;
		for (int a = 0; a < 4; a++) r.crd[a] = '0;
		if (!unravel) begin
			acc = 0;
			for (int a = 0; a < axes(); a++) begin
				if (c[a] >= eff_ext(a)) begin
					r.status = 1'b1;
					acc = 0;
					break;
				end
				acc = (acc + longint'(c[a]) * stride[a]) & 64'hFFFF_FFFF_FFFF;
			end
			r.lin = acc[47:0];
		end else begin
			for (int a = 0; a < axes(); a++)
				if (stride[a] != 0)
					r.crd[a] = 12'((longint'(lin) / stride[a]) % eff_ext(a));
		end
		pending.push_back(r);
	endfunction

	function void check_result(logic [95:0] d, logic st);
		conv_result_t e;
		bit bad;
		if (pending.size() == 0) begin
			errors++;
			if (errors <= 10) $display("unexpected result %h status %b", d, st);
			return;
		end
		e = pending.pop_front();
		bad = (d[47:0] !== e.lin) || (st !== e.status);
		for (int a = 0; a < 4; a++) bad |= (d[48 + 12*a +: 12] !== e.crd[a]);
		if (bad) begin
			errors++;
			if (errors <= 10)
				$display("mismatch: exp lin %h crd %h %h %h %h st %b, got lin %h crd %h %h %h %h st %b",
					e.lin, e.crd[0], e.crd[1], e.crd[2], e.crd[3], e.status,
					d[47:0], d[59:48], d[71:60], d[83:72], d[95:84], st);
		end
	endfunction
endclass

module tb;
	localparam int REG_SPARE   = 5;     // decodes to nothing, write must be dropped
	localparam int DRAIN_WAIT  = 80;    // a margin beyond the pipeline latency
	localparam int STALL_LIMIT = 5000;  // idle cycles before the watchdog fires

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [95:0] s_axis_tdata;    // linear_index[47:0], coord_0..coord_3 12b each
	logic [0:0]  s_axis_tuser;    // req_type
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [95:0] m_axis_tdata;    // linear_out[47:0], coord_out_0..coord_out_3 12b each
	logic [0:0]  m_axis_tuser;    // status
	logic        psel, penable, pwrite;
	logic [4:0]  paddr;
	logic [31:0] pwdata, prdata;
	logic        pready;

	conv_scoreboard sb;
	bit quiet;          // no idling on either side in the closing phase
	int idle_cycles;
	int sink_hold;

	nd_index_ravel_unravel_top u_dut (.*);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// result side: random stall bursts, sampled on the rising edge
	always @(negedge clk) begin
		if (quiet || !arst_n) begin
			m_axis_tready <= 1'b1;
			sink_hold = 0;
		end else if (sink_hold > 0) begin
			m_axis_tready <= 1'b0;
			sink_hold--;
		end else if ($urandom_range(0, 9) == 0) begin
			m_axis_tready <= 1'b0;
			sink_hold = $urandom_range(0, 12);
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk)
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata, m_axis_tuser[0]);

	// watchdog: any handshake on either stream resets the count
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			idle_cycles = 0;
		end else if (++idle_cycles >= STALL_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// two-phase APB write; the register takes it on the access edge
	task automatic reg_write(int idx, logic [31:0] v);
		@(negedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= 5'(4 * idx); pwdata <= v;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.write_reg(idx, v);
		@(negedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
	endtask

	// source goes idle first so the last item is not offered again
	task automatic wait_drained();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
	endtask

	task automatic set_shape(int n, int e0, int e1, int e2, int e3);
		wait_drained();
		reg_write(nirx_pkg::REG_NUM_AXES, n);
		reg_write(nirx_pkg::REG_EXTENT_0, e0);
		reg_write(nirx_pkg::REG_EXTENT_1, e1);
		reg_write(nirx_pkg::REG_EXTENT_2, e2);
		reg_write(nirx_pkg::REG_EXTENT_3, e3);
	endtask

	// valid stays high across back-to-back items; lowered only for a gap or a drain
	task automatic send_item(logic unravel, logic [47:0] lin, logic [11:0] c [4]);
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= unravel;
		s_axis_tdata  <= {c[3], c[2], c[1], c[0], lin};
		do @(posedge clk); while (!s_axis_tready);
		sb.note_item(unravel, lin, c);
	endtask

	task automatic source_gap(int n);
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		repeat (n - 1) @(negedge clk);
	endtask

	function automatic logic [47:0] rand48();
		return {16'($urandom), 32'($urandom)};
	endfunction

	// mostly well-formed requests, with raw full-range values mixed in
	task automatic random_items(int count);
		logic [11:0] c [4];
		logic [47:0] lin;
		int pick;
		for (int i = 0; i < count; i++) begin
			if (!quiet && $urandom_range(0, 7) == 0) source_gap($urandom_range(1, 13));
			pick = $urandom_range(0, 99);
			for (int a = 0; a < 4; a++)
				c[a] = (pick < 55) ? 12'($urandom_range(0, int'(sb.eff_ext(a)) - 1))
				                   : 12'($urandom);
			lin = rand48();
			if (pick >= 70 && pick < 95) lin = 48'(longint'(lin) % sb.span());
			send_item(pick >= 65, lin, c);
		end
	endtask

	initial begin
		logic [11:0] c [4];
		int n;
		sb = new();
		quiet = 1'b0;
		idle_cycles = 0;
		sink_hold = 0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0; s_axis_tdata = '0; s_axis_tuser = '0;
		m_axis_tready = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		// reset shape: one axis of extent one
		c = '{12'd0, 12'd0, 12'd0, 12'd0};
		send_item(1'b0, '0, c);
		c = '{12'd1, 12'd0, 12'd0, 12'd0};
		send_item(1'b0, '0, c);                  // out of range on axis 0
		send_item(1'b1, 48'hFFFF_FFFF_FFFF, c);

		// largest shape: every coordinate valid, span is exactly 2^48
		set_shape(4, 4096, 4096, 4096, 4096);
		c = '{12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF};
		send_item(1'b0, '0, c);
		c = '{12'h000, 12'h000, 12'h000, 12'h000};
		send_item(1'b0, 48'hFFFF_FFFF_FFFF, c);
		send_item(1'b1, 48'hFFFF_FFFF_FFFF, c);
		send_item(1'b1, '0, c);
		send_item(1'b1, 48'hA5A5_5A5A_F00F, c);

		// saturating register values, an unused index, oversized offsets
		set_shape(7, 8191, 0, 5, 4097);
		reg_write(REG_SPARE, 32'hFFFF_FFFF);
		c = '{12'hFFF, 12'h000, 12'h004, 12'hFFF};
		send_item(1'b0, '0, c);
		c = '{12'h000, 12'h001, 12'h004, 12'hFFF};
		send_item(1'b0, '0, c);                  // axis 1 extent zero reads as one
		c = '{12'h123, 12'h000, 12'h003, 12'h456};
		send_item(1'b0, '0, c);
		send_item(1'b1, 48'hFFFF_FFFF_FFFF, c);
		send_item(1'b1, 48'h0000_0000_5000, c);

		// axis count zero reads as one; coords of the other axes are ignored
		set_shape(0, 100, 0, 0, 0);
		c = '{12'd99, 12'hFFF, 12'hFFF, 12'hFFF};
		send_item(1'b0, '0, c);
		c = '{12'd100, 12'd0, 12'd0, 12'd0};
		send_item(1'b0, '0, c);
		send_item(1'b1, 48'd12345, c);           // wraps on axis 0

		// random phases over a spread of shapes
		random_items(150);
		set_shape(2, 4096, 3, 1, 1);
		random_items(150);
		source_gap($urandom_range(1, 13));
		wait_drained();                          // drain completely mid-phase
		random_items(100);
		set_shape(3, 7, 1, 13, 9);
		random_items(160);
		set_shape(4, 2, 3, 5, 7);
		random_items(160);
		set_shape(5, 1, 4096, 4096, 4096);
		random_items(160);
		for (int p = 0; p < 3; p++) begin
			n = $urandom_range(0, 7);
			set_shape(n, $urandom_range(0, 8191), $urandom_range(1, 64),
				$urandom_range(1, 4096), $urandom_range(0, 300));
			random_items(140);
		end
		set_shape(4, 16, 4096, 9, 31);
		quiet = 1'b1;
		random_items(130);

		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		wait_drained();
		repeat (DRAIN_WAIT) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule
